FILE: rtl/abdt_pkg.sv
package abdt_pkg;

    // Highest power in the Taylor series of the fractional exponential.
    localparam int EXP_TERMS = 10;

    // Register stages of the exponential unit, from its input register to its result.
    localparam int EXP_LAT = 2 * EXP_TERMS + 2;

    // Register stages from an accepted beat to the output register.
    localparam int DEC_LAT = EXP_LAT + 5;

    // log2(e) in Q.30 and ln(2) in Q.28.
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [27:0] LN2_Q28   = 28'd186065279;

    // Largest exponential result, unsigned Q12.16.
    localparam logic [27:0] EXP_MAX = 28'hFFFFFFF;

    // Limits of a box coordinate, signed Q14.4.
    localparam logic signed [29:0] BOX_MIN = -30'sd262144;
    localparam logic signed [29:0] BOX_MAX = 30'sd262143;

    typedef logic signed [18:0] t_box;

    // Configuration register indexes; the last index has no register behind it.
    typedef enum logic [2:0] {
        REG_SCORE_THRESHOLD   = 3'd0,
        REG_VARIANCE_CENTER_X = 3'd1,
        REG_VARIANCE_CENTER_Y = 3'd2,
        REG_VARIANCE_WIDTH    = 3'd3,
        REG_VARIANCE_HEIGHT   = 3'd4,
        REG_IMAGE_HEIGHT      = 3'd5,
        REG_IMAGE_WIDTH       = 3'd6,
        REG_UNUSED            = 3'd7
    } t_cfg_reg;

    // Reciprocal of k scaled by 2^32 and rounded up; exact floor division for 28-bit values.
    function automatic logic [31:0] recip(input int k);
        logic [31:0] m;
        begin
            unique case (k)
                2:       m = 32'd2147483648;
                3:       m = 32'd1431655766;
                4:       m = 32'd1073741824;
                5:       m = 32'd858993460;
                6:       m = 32'd715827883;
                7:       m = 32'd613566757;
                8:       m = 32'd536870912;
                9:       m = 32'd477218589;
                10:      m = 32'd429496730;
                default: m = 32'd0;
            endcase
            return m;
        end
    endfunction

    // Clamp a pixel coordinate to the Q14.4 range.
    function automatic t_box sat_box(input logic signed [29:0] p);
        t_box b;
        begin
            if (p < BOX_MIN) begin
                b = BOX_MIN[18:0];
            end else if (p > BOX_MAX) begin
                b = BOX_MAX[18:0];
            end else begin
                b = p[18:0];
            end
            return b;
        end
    endfunction

endpackage

FILE: rtl/abdt_exp.sv
module abdt_exp (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_ts,
    output logic [27:0]        o_e
);

    localparam int N = abdt_pkg::EXP_TERMS;

    typedef struct packed {
        logic signed [4:0] n;
        logic [27:0]       g;
        logic [29:0]       sum;
    } t_ctx;

    logic signed [63:0] y_prod;
    logic signed [32:0] r_y;
    logic [55:0]        g_prod;
    t_ctx               r_ctx0;

    logic [27:0] term_prev [2:N];
    t_ctx        ctx_prev  [2:N];
    logic [55:0] mul_p     [2:N];
    logic [59:0] div_p     [2:N];
    logic [27:0] r_x       [2:N];
    logic [27:0] r_term    [2:N];
    t_ctx        r_ctx_m   [2:N];
    t_ctx        r_ctx_d   [2:N];

    logic [29:0]       r_sumf;
    logic signed [4:0] r_nf;
    logic signed [5:0] n_ext;
    logic [5:0]        sh;
    logic [29:0]       t_shift;
    logic [30:0]       t_inc;
    logic [29:0]       e_round;
    logic [27:0]       n_e;
    logic [27:0]       r_e;

    // Range reduction: the argument times log2(e), then the fraction back to a natural base.
    assign y_prod = i_ts * $signed({1'b0, abdt_pkg::LOG2E_Q30});
    assign g_prod = r_y[27:0] * abdt_pkg::LN2_Q28;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y        <= y_prod[62:30];
            r_ctx0.n   <= r_y[32:28];
            r_ctx0.g   <= g_prod[55:28];
            r_ctx0.sum <= 30'd268435456;
        end
    end

    // Each Taylor term past g takes two stages: a multiply by g, then a divide by k as a reciprocal multiply.
    for (genvar k = 2; k <= N; k++) begin : g_term
        localparam logic [31:0] RECIP = abdt_pkg::recip(k);
        if (k == 2) begin : g_first
            assign term_prev[k] = r_ctx0.g;
            assign ctx_prev[k]  = r_ctx0;
        end else begin : g_next
            assign term_prev[k] = r_term[k-1];
            assign ctx_prev[k]  = r_ctx_d[k-1];
        end
        assign mul_p[k] = term_prev[k] * ctx_prev[k].g;
        assign div_p[k] = r_x[k] * RECIP;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 2; k <= N; k++) begin
                r_x[k]         <= mul_p[k][55:28];
                r_ctx_m[k].n   <= ctx_prev[k].n;
                r_ctx_m[k].g   <= ctx_prev[k].g;
                r_ctx_m[k].sum <= ctx_prev[k].sum + {2'b00, term_prev[k]};
                r_term[k]      <= div_p[k][59:32];
                r_ctx_d[k]     <= r_ctx_m[k];
            end
            r_sumf <= r_ctx_d[N].sum + {2'b00, r_term[N]};
            r_nf   <= r_ctx_d[N].n;
            r_e    <= n_e;
        end
    end

    // Scale by 2^n into Q12.16 with round half up, then saturate.
    always_comb begin
        n_ext   = {r_nf[4], r_nf};
        sh      = 6'(6'sd11 - n_ext);
        t_shift = r_sumf >> sh;
        t_inc   = {1'b0, t_shift} + 31'd1;
        e_round = t_inc[30:1];
        if (n_ext >= 6'sd12) begin
            n_e = abdt_pkg::EXP_MAX;
        end else if (e_round > {2'b00, abdt_pkg::EXP_MAX}) begin
            n_e = abdt_pkg::EXP_MAX;
        end else begin
            n_e = e_round[27:0];
        end
    end

    assign o_e = r_e;

endmodule

FILE: rtl/abdt_axis.sv
module abdt_axis (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_off_c,
    input  logic signed [15:0] i_off_s,
    input  logic [15:0]        i_anc_c,
    input  logic [15:0]        i_anc_s,
    input  logic [15:0]        i_var_c,
    input  logic [15:0]        i_var_s,
    input  logic [11:0]        i_img,
    output abdt_pkg::t_box     o_lo,
    output abdt_pkg::t_box     o_hi
);

    localparam int LAT = abdt_pkg::EXP_LAT;

    logic signed [32:0] tc_n;
    logic signed [32:0] ts_n;
    logic signed [32:0] r_tc;
    logic signed [31:0] r_ts;
    logic [15:0]        r_ac;
    logic [15:0]        r_as_dly [LAT+1];
    logic signed [48:0] centre_n;
    logic signed [48:0] r_centre_dly [LAT];
    logic [27:0]        e;
    logic [43:0]        r_half;
    logic signed [48:0] r_centre;
    logic signed [56:0] half_s;
    logic signed [56:0] lo_n;
    logic signed [56:0] hi_n;
    logic signed [36:0] r_lo;
    logic signed [36:0] r_hi;
    logic signed [49:0] qlo_n;
    logic signed [49:0] qhi_n;
    logic signed [49:0] r_qlo;
    logic signed [49:0] r_qhi;
    logic signed [49:0] plo;
    logic signed [49:0] phi;
    abdt_pkg::t_box     r_box_lo;
    abdt_pkg::t_box     r_box_hi;

    // Offsets scaled by their variances, Q.28.
    assign tc_n = i_off_c * $signed({1'b0, i_var_c});
    assign ts_n = i_off_s * $signed({1'b0, i_var_s});

    // Centre in Q.44: anchor centre plus the scaled offset times the anchor size.
    assign centre_n = $signed({5'b00000, r_ac, 28'd0}) + r_tc * $signed({1'b0, r_as_dly[0]});

    abdt_exp u_exp (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_ts  (r_ts),
        .o_e   (e)
    );

    // Corners in Q.44, then down to Q.24.
    assign half_s = $signed({2'b00, r_half, 11'd0});
    assign lo_n   = r_centre - half_s;
    assign hi_n   = r_centre + half_s;

    // Pixel scaling and rounding to Q14.4.
    assign qlo_n = r_lo * $signed({1'b0, i_img});
    assign qhi_n = r_hi * $signed({1'b0, i_img});
    assign plo   = r_qlo + 50'sd524288;
    assign phi   = r_qhi + 50'sd524288;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tc        <= tc_n;
            r_ts        <= ts_n[31:0];
            r_ac        <= i_anc_c;
            r_as_dly[0] <= i_anc_s;
            for (int i = 1; i <= LAT; i++) begin
                r_as_dly[i] <= r_as_dly[i-1];
            end
            r_centre_dly[0] <= centre_n;
            for (int i = 1; i < LAT; i++) begin
                r_centre_dly[i] <= r_centre_dly[i-1];
            end
            r_half   <= e * r_as_dly[LAT];
            r_centre <= r_centre_dly[LAT-1];
            r_lo     <= lo_n[56:20];
            r_hi     <= hi_n[56:20];
            r_qlo    <= qlo_n;
            r_qhi    <= qhi_n;
            r_box_lo <= abdt_pkg::sat_box(plo[49:20]);
            r_box_hi <= abdt_pkg::sat_box(phi[49:20]);
        end
    end

    assign o_lo = r_box_lo;
    assign o_hi = r_box_hi;

endmodule

FILE: rtl/anchor_box_decode_threshold.sv
// Anchor box decoder with a score threshold.
// Input channel (i_valid / o_ready): one beat is one anchor-class pair: four Q3.12
// offsets, four Q0.16 anchor values, a Q0.16 score and its class number.
// Output channel (o_valid / i_ready): one beat per passing input, carrying the
// score and the box corners in pixels as saturated signed Q14.4.
// A beat passes when its class is neither background nor at or above NUM_CLASSES
// and its score is strictly above the threshold; other beats produce nothing.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must write it only while idle, which the block does not enforce. One beat is
// taken every cycle unless the output stalls; the depth is set by the exponential
// up to its tenth power, two stages per term past g. When the receiver stalls with
// a result waiting, the whole pipeline holds and o_ready falls; bubbles ahead of
// the output keep flowing while it is empty. Reset clears all pipeline valid bits
// and loads the default threshold, variances and image size.
module anchor_box_decode_threshold #(
    parameter int NUM_CLASSES = 21
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_offset_cx,
    input  logic signed [15:0] i_offset_cy,
    input  logic signed [15:0] i_offset_w,
    input  logic signed [15:0] i_offset_h,
    input  logic [15:0]        i_anchor_cx,
    input  logic [15:0]        i_anchor_cy,
    input  logic [15:0]        i_anchor_w,
    input  logic [15:0]        i_anchor_h,
    input  logic [15:0]        i_class_score,
    input  logic [4:0]         i_class_number,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_score,
    output logic signed [18:0] o_box_xmin,
    output logic signed [18:0] o_box_ymin,
    output logic signed [18:0] o_box_xmax,
    output logic signed [18:0] o_box_ymax
);

    localparam int LAT = abdt_pkg::DEC_LAT;

    logic [15:0] r_score_threshold;
    logic [15:0] r_variance_center_x;
    logic [15:0] r_variance_center_y;
    logic [15:0] r_variance_width;
    logic [15:0] r_variance_height;
    logic [11:0] r_image_height;
    logic [11:0] r_image_width;

    logic           en;
    logic           pass;
    logic [LAT-1:0] r_vld;
    logic [15:0]    r_score [LAT];
    abdt_pkg::t_box box_xmin;
    abdt_pkg::t_box box_ymin;
    abdt_pkg::t_box box_xmax;
    abdt_pkg::t_box box_ymax;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_threshold   <= 16'd32768;
            r_variance_center_x <= 16'd6554;
            r_variance_center_y <= 16'd6554;
            r_variance_width    <= 16'd13107;
            r_variance_height   <= 16'd13107;
            r_image_height      <= 12'd300;
            r_image_width       <= 12'd300;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                abdt_pkg::REG_SCORE_THRESHOLD:   r_score_threshold   <= i_cfg_data;
                abdt_pkg::REG_VARIANCE_CENTER_X: r_variance_center_x <= i_cfg_data;
                abdt_pkg::REG_VARIANCE_CENTER_Y: r_variance_center_y <= i_cfg_data;
                abdt_pkg::REG_VARIANCE_WIDTH:    r_variance_width    <= i_cfg_data;
                abdt_pkg::REG_VARIANCE_HEIGHT:   r_variance_height   <= i_cfg_data;
                abdt_pkg::REG_IMAGE_HEIGHT:      r_image_height      <= i_cfg_data[11:0];
                abdt_pkg::REG_IMAGE_WIDTH:       r_image_width       <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // The pipeline moves unless a finished result is held by the receiver.
    assign en      = ~r_vld[LAT-1] | i_ready;
    assign o_ready = en;

    // Class and score filter; a failing beat enters as a bubble.
    assign pass = (i_class_number != 5'd0)
                && ({27'd0, i_class_number} < 32'(NUM_CLASSES))
                && (i_class_score > r_score_threshold);

    // Valid bits travel alongside the datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid & pass};
        end
    end

    // The score rides along to the output stage.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_score[0] <= i_class_score;
            for (int i = 1; i < LAT; i++) begin
                r_score[i] <= r_score[i-1];
            end
        end
    end

    abdt_axis u_axis_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_off_c (i_offset_cx),
        .i_off_s (i_offset_w),
        .i_anc_c (i_anchor_cx),
        .i_anc_s (i_anchor_w),
        .i_var_c (r_variance_center_x),
        .i_var_s (r_variance_width),
        .i_img   (r_image_width),
        .o_lo    (box_xmin),
        .o_hi    (box_xmax)
    );

    abdt_axis u_axis_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_off_c (i_offset_cy),
        .i_off_s (i_offset_h),
        .i_anc_c (i_anchor_cy),
        .i_anc_s (i_anchor_h),
        .i_var_c (r_variance_center_y),
        .i_var_s (r_variance_height),
        .i_img   (r_image_height),
        .o_lo    (box_ymin),
        .o_hi    (box_ymax)
    );

    assign o_valid    = r_vld[LAT-1];
    assign o_score    = r_score[LAT-1];
    assign o_box_xmin = box_xmin;
    assign o_box_ymin = box_ymin;
    assign o_box_xmax = box_xmax;
    assign o_box_ymax = box_ymax;

endmodule
